### rtl/ftfre_pkg.sv
// types and constants shared by the ring encoder modules
`timescale 1ns / 1ps
package ftfre_pkg;

  typedef enum logic [3:0] {
    FMT_F16  = 4'd0,
    FMT_F32  = 4'd1,
    FMT_F64  = 4'd2,
    FMT_I8   = 4'd3,
    FMT_U8   = 4'd4,
    FMT_I16  = 4'd5,
    FMT_U16  = 4'd6,
    FMT_I32  = 4'd7,
    FMT_U32  = 4'd8,
    FMT_I64  = 4'd9,
    FMT_U64  = 4'd10,
    FMT_BOOL = 4'd11
  } fmt_t;

  localparam logic [1:0] REG_RING = 2'd0;
  localparam logic [1:0] REG_FRAC = 2'd1;
  localparam logic [1:0] REG_FMT  = 2'd2;

  // decoded element after stage 1
  typedef struct packed {
    logic        is_float;
    logic        is_nan;
    logic        sign;
    logic [11:0] exp;      // unbiased exponent + 2048 offset
    logic [52:0] mant;     // with hidden bit, msb aligned at bit 52
    logic        is_zero;
    logic [63:0] int_val;
    logic        err;
    logic        ring64;
    logic [5:0]  frac;
    logic [1:0]  prec;     // 0 half, 1 single, 2 double
    logic        last;
  } dec_t;

  // stage 2 result
  typedef struct packed {
    logic        is_float;
    logic        sat_hi;
    logic        sat_lo;
    logic        sign;
    logic [63:0] mag;
    logic [63:0] int_val;
    logic        err;
    logic        ring64;
    logic        last;
  } scl_t;

endpackage

### rtl/ftfre_decode.sv
// stage 1: unpack source format into sign, exponent and mantissa
`timescale 1ns / 1ps
module ftfre_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [63:0]        source_bits,
  input  logic               last_in,
  input  logic               ring_select,
  input  logic [5:0]         frac_bits,
  input  logic [3:0]         source_format,
  output logic               valid,
  output ftfre_pkg::dec_t    dec
);

  ftfre_pkg::dec_t dec_next;
  logic [4:0]  he;
  logic [9:0]  hm;
  logic [7:0]  se;
  logic [22:0] sm;
  logic [10:0] de;
  logic [51:0] dm;
  logic [3:0]  lz;
  logic        fmt_float;

  always_comb begin
    dec_next = '0;
    he = source_bits[14:10];
    hm = source_bits[9:0];
    se = source_bits[30:23];
    sm = source_bits[22:0];
    de = source_bits[62:52];
    dm = source_bits[51:0];
    lz = 4'd0;
    dec_next.ring64 = ring_select;
    dec_next.frac   = frac_bits;
    dec_next.last   = last_in;
    fmt_float = (source_format == ftfre_pkg::FMT_F16) ||
                (source_format == ftfre_pkg::FMT_F32) ||
                (source_format == ftfre_pkg::FMT_F64);
    dec_next.is_float = fmt_float;
    if (fmt_float && ({1'b0, frac_bits} > (ring_select ? 7'd62 : 7'd30))) begin
      dec_next.is_float = 1'b0;
      dec_next.err = 1'b1;
    end
    case (source_format)
      ftfre_pkg::FMT_F16: begin
        dec_next.prec = 2'd0;
        dec_next.sign = source_bits[15];
        if (he == 5'd31) begin
          dec_next.is_nan = (hm != 10'd0);
          dec_next.exp  = 12'd2048 + 12'd1000;
          dec_next.mant = {1'b1, 52'd0};
        end else if (he == 5'd0) begin
          dec_next.is_zero = (hm == 10'd0);
          for (int i = 0; i < 10; i++) if (hm[i]) lz = 4'(9 - i);
          dec_next.mant = {10'(hm << lz), 43'd0};
          dec_next.exp  = 12'd2048 - 12'd15 - 12'(lz);
        end else begin
          dec_next.exp  = 12'd2048 + 12'(he) - 12'd15;
          dec_next.mant = {1'b1, hm, 42'd0};
        end
      end
      ftfre_pkg::FMT_F32: begin
        dec_next.prec = 2'd1;
        dec_next.sign = source_bits[31];
        if (se == 8'hFF) begin
          dec_next.is_nan = (sm != 23'd0);
          dec_next.exp  = 12'd2048 + 12'd1000;
          dec_next.mant = {1'b1, 52'd0};
        end else if (se == 8'd0) begin
          dec_next.is_zero = (sm == 23'd0);
          dec_next.exp  = 12'd2048 - 12'd126;
          dec_next.mant = {1'b0, sm, 29'd0};
        end else begin
          dec_next.exp  = 12'd2048 + 12'(se) - 12'd127;
          dec_next.mant = {1'b1, sm, 29'd0};
        end
      end
      ftfre_pkg::FMT_F64: begin
        dec_next.prec = 2'd2;
        dec_next.sign = source_bits[63];
        if (de == 11'h7FF) begin
          dec_next.is_nan = (dm != 52'd0);
          dec_next.exp  = 12'd2048 + 12'd1000;
          dec_next.mant = {1'b1, 52'd0};
        end else if (de == 11'd0) begin
          dec_next.is_zero = (dm == 52'd0);
          dec_next.exp  = 12'd2048 - 12'd1022;
          dec_next.mant = {1'b0, dm};
        end else begin
          dec_next.exp  = 12'd2048 + 12'(de) - 12'd1023;
          dec_next.mant = {1'b1, dm};
        end
      end
      ftfre_pkg::FMT_I8:  dec_next.int_val = {{56{source_bits[7]}}, source_bits[7:0]};
      ftfre_pkg::FMT_U8:  dec_next.int_val = {56'd0, source_bits[7:0]};
      ftfre_pkg::FMT_I16: dec_next.int_val = {{48{source_bits[15]}}, source_bits[15:0]};
      ftfre_pkg::FMT_U16: dec_next.int_val = {48'd0, source_bits[15:0]};
      ftfre_pkg::FMT_I32: dec_next.int_val = {{32{source_bits[31]}}, source_bits[31:0]};
      ftfre_pkg::FMT_U32: dec_next.int_val = {32'd0, source_bits[31:0]};
      ftfre_pkg::FMT_I64, ftfre_pkg::FMT_U64: begin
        dec_next.int_val = ring_select ? source_bits : 64'd0;
        dec_next.err     = !ring_select;
      end
      ftfre_pkg::FMT_BOOL: dec_next.int_val = {63'd0, (source_bits[7:0] != 8'd0)};
      default: dec_next.err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec <= dec_next;
    end
  end

endmodule

### rtl/ftfre_scale.sv
// stage 2: bound compare and shift of the mantissa to the fixed-point grid
`timescale 1ns / 1ps
module ftfre_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  ftfre_pkg::dec_t    dec,
  output logic               valid,
  output ftfre_pkg::scl_t    scl
);

  ftfre_pkg::scl_t scl_next;
  logic [12:0] ex;      // k-2-f, offset by 2048
  logic [12:0] pos;     // exponent + f, offset by 2048
  logic [6:0]  km2;
  logic [6:0]  pbits;
  logic        big;
  logic        all_ones;
  logic [52:0] pmask;
  logic [12:0] sh;

  always_comb begin
    scl_next = '0;
    scl_next.is_float = dec.is_float && !dec.is_nan;
    scl_next.sign     = dec.sign;
    scl_next.int_val  = dec.int_val;
    scl_next.err      = dec.err;
    scl_next.ring64   = dec.ring64;
    scl_next.last     = dec.last;
    km2   = dec.ring64 ? 7'd62 : 7'd30;
    case (dec.prec)
      2'd0:    pbits = 7'd11;
      2'd1:    pbits = 7'd24;
      default: pbits = 7'd53;
    endcase
    ex  = 13'd2048 + 13'(km2) - 13'(dec.frac);
    pos = 13'(dec.exp) + 13'(dec.frac);
    big = (km2 > pbits);
    // mantissa all ones within source precision: value is ub = (2^(k-2)-1)/2^f
    pmask = 53'h1FFFFFFFFFFFFF >> (7'd53 - pbits);
    pmask = pmask << (7'd53 - pbits);
    all_ones = ((dec.mant & pmask) == pmask);
    if (dec.is_zero) begin
      scl_next.sat_hi = 1'b0;
      scl_next.sat_lo = 1'b0;
    end else if (dec.prec == 2'd0 && ex >= 13'd2048 + 13'd16) begin
      scl_next.sat_hi = !dec.sign && dec.exp == 12'd2048 + 12'd1000;
      scl_next.sat_lo =  dec.sign && dec.exp == 12'd2048 + 12'd1000;
    end else begin
      // value magnitude >= 2^ex
      scl_next.sat_lo = dec.sign && ({1'b0, dec.exp} >= ex);
      if (big)
        scl_next.sat_hi = !dec.sign && ({1'b0, dec.exp} >= ex);
      else
        scl_next.sat_hi = !dec.sign && (({1'b0, dec.exp} >= ex) ||
                          (({1'b0, dec.exp} + 13'd1 == ex) && all_ones));
    end
    // integer part = mant * 2^(pos-2048-52)
    if (pos < 13'd2048 - 13'd1) begin
      sh = 13'd0;
      scl_next.mag = 64'd0;
    end else begin
      sh = pos - 13'd2048 + 13'd1;
      if (sh > 13'd64) sh = 13'd64;
      scl_next.mag = 64'((117'(dec.mant) << sh[6:0]) >> 53);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scl <= scl_next;
    end
  end

endmodule

### rtl/ftfre_pack.sv
// stage 3: saturation, sign, ring wrap into the output register
`timescale 1ns / 1ps
module ftfre_pack (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  ftfre_pkg::scl_t    scl,
  output logic               valid,
  output logic [63:0]        ring_value,
  output logic               encode_error,
  output logic               last_out
);

  logic [63:0] top;
  logic [63:0] val;

  always_comb begin
    top = scl.ring64 ? 64'h4000000000000000 : 64'h0000000040000000;
    if (scl.is_float) begin
      if (scl.sat_hi)      val = top - 64'd1;
      else if (scl.sat_lo) val = 64'd0 - top;
      else if (scl.sign)   val = 64'd0 - scl.mag;
      else                 val = scl.mag;
    end else begin
      val = scl.int_val;
    end
    if (!scl.ring64) val = {{32{val[31]}}, val[31:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ring_value   <= val;
      encode_error <= scl.err;
      last_out     <= scl.last;
    end
  end

endmodule

### rtl/float_to_fixed_ring_encoder_unit.sv
// top level of the float to fixed-point ring encoder
// pipeline: input beat passes the decode, scale and pack stages to the output beat
// throughput: one beat per cycle; the pipeline stalls as a whole on m_tready
// reset: clears all stage valid bits; ring_select 1, frac_bits 18, source f64
// config beats are always taken
`timescale 1ns / 1ps
module float_to_fixed_ring_encoder_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // source_bits
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // ring_value, encode_error, zero fill
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [5:0]   cfg_data
);

  logic            ring_select;
  logic [5:0]      frac_bits;
  logic [3:0]      source_format;
  logic            adv;
  logic            v1;
  logic            v2;
  logic [63:0]     ring_value;
  logic            encode_error;
  ftfre_pkg::dec_t dec;
  ftfre_pkg::scl_t scl;

  assign cfg_ready = 1'b1;
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign m_tdata   = {7'd0, encode_error, ring_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_select   <= 1'b1;
      frac_bits     <= 6'd18;
      source_format <= 4'(ftfre_pkg::FMT_F64);
    end else if (cfg_valid) begin
      case (cfg_index)
        ftfre_pkg::REG_RING: ring_select   <= cfg_data[0];
        ftfre_pkg::REG_FRAC: frac_bits     <= cfg_data;
        ftfre_pkg::REG_FMT:  source_format <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  ftfre_decode u_decode (
    .clk, .rst, .adv,
    .in_valid(s_tvalid), .source_bits(s_tdata), .last_in(s_tlast),
    .ring_select, .frac_bits, .source_format,
    .valid(v1), .dec
  );

  ftfre_scale u_scale (
    .clk, .rst, .adv, .in_valid(v1), .dec, .valid(v2), .scl
  );

  ftfre_pack u_pack (
    .clk, .rst, .adv, .in_valid(v2), .scl,
    .valid(m_tvalid), .ring_value, .encode_error, .last_out(m_tlast)
  );

endmodule

### rtl/ftfre_checker.sv
// port-level checks for the ring encoder
`timescale 1ns / 1ps
module ftfre_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready ##1 s_tready ##1 s_tready |=> m_tvalid)
    else $error("beat lost in pipeline");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:65] == 7'd0)
    else $error("fill bits set");

endmodule

bind float_to_fixed_ring_encoder_unit ftfre_checker u_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
